FILE: hw/rtl/gait_phase_ramp_shaper_core_assert.svh
// Assertion macros for the gait phase ramp shaper.
// The macros expect a signal named clk, and GPR_ASSERT also one named rst_n, in the module where they are used.
// Define NO_ASSERTIONS to compile every use to nothing.
`ifndef GAIT_PHASE_RAMP_SHAPER_CORE_ASSERT_SVH
`define GAIT_PHASE_RAMP_SHAPER_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Checked property that is disabled while reset is active.
`define GPR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked property that must also hold during reset.
`define GPR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define GPR_ASSERT(lbl, prop, msg)
`define GPR_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

FILE: hw/rtl/gpr_pkg.sv
// Shared types and constants for the gait phase ramp shaper.
// Used by gpr_ctrl, gpr_dpath and gait_phase_ramp_shaper_core. No dependencies.
`default_nettype none

package gpr_pkg;

    localparam int COUNT_BITS = 16;
    localparam int Q_BITS     = 16;
    localparam int NUM_BITS   = COUNT_BITS + Q_BITS;
    localparam int ITER_BITS  = $clog2(Q_BITS);

    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
    localparam logic [ITER_BITS-1:0]  ITER_LAST = ITER_BITS'(Q_BITS - 1);

    localparam logic [1:0] PH_UNKNOWN = 2'd0;
    localparam logic [1:0] PH_HIGH    = 2'd1;
    localparam logic [1:0] PH_LOW     = 2'd2;

    localparam logic signed [15:0] THRESH_RESET = 16'sd13926;

    // Q2.14 constants, one bit wider than the fields for the ramp arithmetic.
    localparam logic [16:0] ONE_Q = 17'd16384;
    localparam logic [16:0] TWO_Q = 17'd32768;

    typedef struct packed {
        logic signed [15:0] activity_a;
        logic signed [15:0] activity_b;
    } item_t;

    typedef struct packed {
        logic signed [15:0] shaped_a;
        logic signed [15:0] shaped_b;
    } result_t;

    typedef struct packed {
        logic accept;
        logic load;
        logic step;
        logic store;
        logic publish;
        logic ch;
    } cmd_t;

    typedef struct packed {
        logic div_last;
    } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/gpr_ctrl.sv
// Sequencer for the gait phase ramp shaper: handshakes and divider steps.
// Depends on gpr_pkg and gait_phase_ramp_shaper_core_assert.svh.
`default_nettype none
`include "gait_phase_ramp_shaper_core_assert.svh"

module gpr_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    output logic                item_stall,
    output logic                result_valid,
    input  wire logic           result_stall,
    input  wire gpr_pkg::status_t status,
    output gpr_pkg::cmd_t       cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STORE = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       ch_reg, ch_next;
    logic       valid_reg, valid_next;

    always_comb
    begin
        state_next  = state_reg;
        ch_next     = ch_reg;
        cmd         = '0;
        cmd.ch      = ch_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.accept = 1'b1;
                    ch_next    = 1'b0;
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                cmd.step = 1'b1;
                if (status.div_last)
                begin
                    state_next = S_STORE;
                end
            end
            S_STORE:
            begin
                cmd.store = 1'b1;
                if (!ch_reg)
                begin
                    ch_next    = 1'b1;
                    state_next = S_LOAD;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // The output register is free once its last transfer completes.
                if (!valid_reg || !result_stall)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.publish)
        begin
            valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ch_reg    <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            valid_reg <= valid_next;
        end
    end

    assign item_stall   = (state_reg != S_IDLE);
    assign result_valid = valid_reg;

    `GPR_ASSERT(a_accept_starts_ch0, (item_valid && !item_stall) |=> (state_reg == S_LOAD && ch_reg == 1'b0), "accepted item did not start on channel A")
    `GPR_ASSERT(a_ch0_then_ch1, (state_reg == S_STORE && ch_reg == 1'b0) |=> (state_reg == S_LOAD && ch_reg == 1'b1), "channel B did not follow channel A")
    `GPR_ASSERT(a_result_from_fin, $rose(result_valid) |-> ($past(state_reg) == S_FIN && $past(ch_reg) == 1'b1), "result raised outside the finish step")

endmodule

`default_nettype wire

FILE: hw/rtl/gpr_dpath.sv
// Datapath of the gait phase ramp shaper: phase state, shared serial divider, results.
// Depends on gpr_pkg and gait_phase_ramp_shaper_core_assert.svh.
`default_nettype none
`include "gait_phase_ramp_shaper_core_assert.svh"

module gpr_dpath (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cfg_write,
    input  wire logic signed [15:0]  cfg_data,
    input  wire gpr_pkg::item_t      item,
    input  wire gpr_pkg::cmd_t       cmd,
    output gpr_pkg::status_t         status,
    output gpr_pkg::result_t         result
);

    localparam int CB = gpr_pkg::COUNT_BITS;
    localparam int QB = gpr_pkg::Q_BITS;
    localparam int NB = gpr_pkg::NUM_BITS;

    logic signed [15:0] thr_reg, thr_next;

    logic [1:0]    phase_reg   [2];
    logic [1:0]    phase_next  [2];
    logic [CB-1:0] hi_cnt_reg  [2];
    logic [CB-1:0] hi_cnt_next [2];
    logic [CB-1:0] lo_cnt_reg  [2];
    logic [CB-1:0] lo_cnt_next [2];
    logic [CB-1:0] hi_per_reg  [2];
    logic [CB-1:0] hi_per_next [2];
    logic [CB-1:0] lo_per_reg  [2];
    logic [CB-1:0] lo_per_next [2];

    logic [CB-1:0] use_cnt_reg   [2];
    logic [CB-1:0] use_cnt_next  [2];
    logic [CB-1:0] use_per_reg   [2];
    logic [CB-1:0] use_per_next  [2];
    logic          use_high_reg  [2];
    logic          use_high_next [2];

    logic signed [15:0] act     [2];
    logic               is_high [2];
    logic [CB-1:0]      hi_inc  [2];
    logic [CB-1:0]      lo_inc  [2];

    logic [CB-1:0]            rem_reg, rem_next;
    logic [QB-1:0]            low_reg, low_next;
    logic [QB-1:0]            quo_reg, quo_next;
    logic                     ovf_reg, ovf_next;
    logic [gpr_pkg::ITER_BITS-1:0] iter_reg, iter_next;

    logic [CB-1:0] sel_cnt;
    logic [CB-1:0] sel_per;
    logic          sel_high;
    logic [NB-1:0] num;
    logic [CB-1:0] num_hi;
    logic [CB:0]   trial;
    logic [CB:0]   diff;
    logic          fits;

    logic [16:0]   q_clamp;
    logic [16:0]   y_wide;
    logic [15:0]   y_reg  [2];
    logic [15:0]   y_next [2];
    gpr_pkg::result_t result_reg, result_next;

    assign thr_next = cfg_write ? cfg_data : thr_reg;

    assign act[0] = item.activity_a;
    assign act[1] = item.activity_b;

    // Phase tracking and run counters, updated when an item transfer is taken.
    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            is_high[c] = (act[c] >= thr_reg);
            hi_inc[c]  = (hi_cnt_reg[c] == gpr_pkg::CNT_MAX) ? gpr_pkg::CNT_MAX
                                                              : hi_cnt_reg[c] + 1'b1;
            lo_inc[c]  = (lo_cnt_reg[c] == gpr_pkg::CNT_MAX) ? gpr_pkg::CNT_MAX
                                                              : lo_cnt_reg[c] + 1'b1;
            phase_next[c]    = phase_reg[c];
            hi_cnt_next[c]   = hi_cnt_reg[c];
            lo_cnt_next[c]   = lo_cnt_reg[c];
            hi_per_next[c]   = hi_per_reg[c];
            lo_per_next[c]   = lo_per_reg[c];
            use_cnt_next[c]  = use_cnt_reg[c];
            use_per_next[c]  = use_per_reg[c];
            use_high_next[c] = use_high_reg[c];
            if (cmd.accept)
            begin
                use_high_next[c] = is_high[c];
                if (is_high[c])
                begin
                    hi_cnt_next[c] = hi_inc[c];
                    lo_cnt_next[c] = '0;
                    if (phase_reg[c] == gpr_pkg::PH_LOW)
                    begin
                        lo_per_next[c] = lo_cnt_reg[c];
                    end
                    phase_next[c]   = gpr_pkg::PH_HIGH;
                    use_cnt_next[c] = hi_inc[c];
                    use_per_next[c] = hi_per_reg[c];
                end
                else
                begin
                    lo_cnt_next[c] = lo_inc[c];
                    hi_cnt_next[c] = '0;
                    if (phase_reg[c] == gpr_pkg::PH_HIGH)
                    begin
                        hi_per_next[c] = hi_cnt_reg[c];
                    end
                    phase_next[c]   = gpr_pkg::PH_LOW;
                    use_cnt_next[c] = lo_inc[c];
                    use_per_next[c] = lo_per_reg[c];
                end
            end
        end
    end

    assign sel_cnt  = use_cnt_reg[cmd.ch];
    assign sel_per  = use_per_reg[cmd.ch];
    assign sel_high = use_high_reg[cmd.ch];

    // Dividend is count * 2^15 plus half the period, for round to nearest.
    assign num    = NB'({sel_cnt, 15'b0}) + NB'(sel_per[CB-1:1]);
    assign num_hi = num[NB-1:QB];

    // One restoring division step per cycle; the remainder stays below the period unless the load flagged an overflow.
    assign trial = {rem_reg, low_reg[QB-1]};
    assign diff  = trial - {1'b0, sel_per};
    assign fits  = (trial >= {1'b0, sel_per});

    always_comb
    begin
        rem_next  = rem_reg;
        low_next  = low_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        iter_next = iter_reg;
        if (cmd.load)
        begin
            rem_next  = num_hi;
            low_next  = num[QB-1:0];
            quo_next  = '0;
            // If the high half reaches the period, the quotient needs more than QB bits, so it clamps anyway.
            ovf_next  = (num_hi >= sel_per);
            iter_next = '0;
        end
        else if (cmd.step)
        begin
            rem_next  = fits ? diff[CB-1:0] : trial[CB-1:0];
            low_next  = {low_reg[QB-2:0], 1'b0};
            quo_next  = {quo_reg[QB-2:0], fits};
            iter_next = iter_reg + 1'b1;
        end
    end

    assign status.div_last = (iter_reg == gpr_pkg::ITER_LAST);

    always_comb
    begin
        if (ovf_reg || ({1'b0, quo_reg} > gpr_pkg::TWO_Q))
        begin
            q_clamp = gpr_pkg::TWO_Q;
        end
        else
        begin
            q_clamp = {1'b0, quo_reg};
        end
        if (sel_high)
        begin
            y_wide = (sel_per == '0) ? gpr_pkg::ONE_Q : q_clamp - gpr_pkg::ONE_Q;
        end
        else
        begin
            y_wide = (sel_per == '0) ? 17'd0 - gpr_pkg::ONE_Q : gpr_pkg::ONE_Q - q_clamp;
        end
    end

    always_comb
    begin
        for (int c = 0; c < 2; c++)
        begin
            y_next[c] = y_reg[c];
            if (cmd.store && (cmd.ch == 1'(c)))
            begin
                y_next[c] = y_wide[15:0];
            end
        end
        result_next = result_reg;
        if (cmd.publish)
        begin
            result_next.shaped_a = y_reg[0];
            result_next.shaped_b = y_reg[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= gpr_pkg::THRESH_RESET;
            for (int c = 0; c < 2; c++)
            begin
                phase_reg[c]  <= gpr_pkg::PH_UNKNOWN;
                hi_cnt_reg[c] <= '0;
                lo_cnt_reg[c] <= '0;
                hi_per_reg[c] <= '0;
                lo_per_reg[c] <= '0;
            end
            iter_reg <= '0;
        end
        else
        begin
            thr_reg <= thr_next;
            for (int c = 0; c < 2; c++)
            begin
                phase_reg[c]  <= phase_next[c];
                hi_cnt_reg[c] <= hi_cnt_next[c];
                lo_cnt_reg[c] <= lo_cnt_next[c];
                hi_per_reg[c] <= hi_per_next[c];
                lo_per_reg[c] <= lo_per_next[c];
            end
            iter_reg <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int c = 0; c < 2; c++)
        begin
            use_cnt_reg[c]  <= use_cnt_next[c];
            use_per_reg[c]  <= use_per_next[c];
            use_high_reg[c] <= use_high_next[c];
            y_reg[c]        <= y_next[c];
        end
        rem_reg    <= rem_next;
        low_reg    <= low_next;
        quo_reg    <= quo_next;
        ovf_reg    <= ovf_next;
        result_reg <= result_next;
    end

    assign result = result_reg;

    `GPR_ASSERT(a_rem_below_period, (cmd.step && !ovf_reg && sel_per != '0) |-> (rem_reg < sel_per), "divider remainder reached the period")
    `GPR_ASSERT(a_result_range, cmd.publish |=> (result_reg.shaped_a <= 16'sd16384 && result_reg.shaped_a >= -16'sd16384 && result_reg.shaped_b <= 16'sd16384 && result_reg.shaped_b >= -16'sd16384), "ramp result outside plus or minus one")
    `GPR_ASSERT_ALWAYS(a_one_run_active, ((hi_cnt_reg[0] == '0 || lo_cnt_reg[0] == '0) && (hi_cnt_reg[1] == '0 || lo_cnt_reg[1] == '0)), "high and low run counts both nonzero")

endmodule

`default_nettype wire

FILE: hw/rtl/gait_phase_ramp_shaper_core.sv
// Gait phase ramp shaper: one result per item. No new item is taken until the last one is
// published: both channels share one radix-2 divider that runs each channel in turn
// through load, 16 quotient bits and store, followed by publish and return to idle.
// The result register holds a finished result; a result still stalled at publish delays the next.
// Reset (rst_n, asynchronous, active low) clears phases, run counts, periods and handshakes,
// and sets the phase threshold to 0.85. Depends on gpr_pkg, gpr_ctrl and gpr_dpath.
`default_nettype none

module gait_phase_ramp_shaper_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write,
    input  wire logic signed [15:0] cfg_data,
    input  wire logic               item_valid,
    output logic                    item_stall,
    input  wire gpr_pkg::item_t     item,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output gpr_pkg::result_t        result
);

    gpr_pkg::cmd_t    cmd;
    gpr_pkg::status_t status;

    gpr_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    gpr_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .item      (item),
        .cmd       (cmd),
        .status    (status),
        .result    (result)
    );

endmodule

`default_nettype wire

FILE: sim/gait_phase_ramp_shaper_core_tb.sv
// Self-checking testbench for gait_phase_ramp_shaper_core: a directed table (some rows with typed
// results), then random runs over several phase thresholds, the rest checked against an in-bench ramp predictor.
// Depends on gpr_pkg and the gait_phase_ramp_shaper_core RTL only.
`default_nettype none

module gait_phase_ramp_shaper_core_tb;

    typedef struct packed {
        logic signed [15:0] act_a;
        logic signed [15:0] act_b;
        logic               typed;
        logic signed [15:0] shaped_a;
        logic signed [15:0] shaped_b;
    } dir_row_t;

    localparam int DIR_ROWS     = 20;
    localparam int NUM_SETTINGS = 7;
    localparam int SETTING_ITEMS = 272;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_write;
    logic signed [15:0] cfg_data;
    logic               item_valid;
    logic               item_stall;
    gpr_pkg::item_t     item;
    logic               result_valid;
    logic               result_stall;
    gpr_pkg::result_t   result;

    // Predictor copy of the per-channel phase tracking.
    logic signed [15:0] thresh_q;
    logic [1:0]         ch_phase [2];
    logic [15:0]        high_cnt [2];
    logic [15:0]        low_cnt [2];
    logic [15:0]        high_len [2];
    logic [15:0]        low_len [2];

    gpr_pkg::result_t   shaped_q [$];
    int                 run_left [2];
    logic               run_high [2];
    bit                 idle_on = 1'b1;
    int                 errors = 0;
    int                 items_sent = 0;
    int                 results_checked = 0;
    int                 rail_outputs = 0;
    int                 cfg_writes = 0;

    // Extremes, the exact threshold, zero periods, first phase change and ramp clamping.
    dir_row_t dir_rows [DIR_ROWS] = '{
        '{16'sd16384, -16'sd16384, 1'b1, 16'sd16384, -16'sd16384},
        '{16'sd13926, 16'sd13925, 1'b1, 16'sd16384, -16'sd16384},
        '{16'sh8000, 16'sh7FFF, 1'b1, -16'sd16384, 16'sd16384},
        '{16'sd0, 16'sd16384, 1'b1, -16'sd16384, 16'sd16384},
        '{16'sd16384, -16'sd16384, 1'b1, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd16384, 1'b0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd16384, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd1, -16'sd16384, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd16384, 16'sd16383, 1'b0, 16'sd0, 16'sd0},
        '{16'sd13925, 16'sd13926, 1'b0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd16383, 1'b0, 16'sd0, 16'sd0},
        '{16'sd16384, -16'sd1, 1'b0, 16'sd0, 16'sd0},
        '{16'sd14000, -16'sd2, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd100, 16'sd13926, 1'b0, 16'sd0, 16'sd0},
        '{-16'sd16384, 16'sh8000, 1'b0, 16'sd0, 16'sd0},
        '{16'sh7FFF, 16'sd0, 1'b0, 16'sd0, 16'sd0},
        '{16'sh8000, 16'sd16384, 1'b0, 16'sd0, 16'sd0},
        '{16'sh5555, 16'shAAAA, 1'b0, 16'sd0, 16'sd0},
        '{16'shAAAA, 16'sh5555, 1'b0, 16'sd0, 16'sd0},
        '{16'sd16384, 16'sd16384, 1'b0, 16'sd0, 16'sd0}
    };

    gait_phase_ramp_shaper_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always #2 clk = ~clk;

    task automatic report_mismatch(string msg);
        errors++;
        if (errors <= 50)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    function automatic logic [16:0] ramp_level(logic [15:0] cnt, logic [15:0] len);
        longint unsigned num;
        longint unsigned q;
        num = 64'(cnt) * 64'(gpr_pkg::TWO_Q) + 64'(len >> 1);
        q = num / 64'(len);
        if (q > 64'(gpr_pkg::TWO_Q))
            q = 64'(gpr_pkg::TWO_Q);
        return q[16:0];
    endfunction

    function automatic logic signed [15:0] shape_step(int ch, logic signed [15:0] act);
        logic [15:0] old_hi;
        logic [15:0] old_lo;
        int          y;
        old_hi = high_cnt[ch];
        old_lo = low_cnt[ch];
        if (act >= thresh_q)
        begin
            high_cnt[ch] = (old_hi == gpr_pkg::CNT_MAX) ? old_hi : old_hi + 16'd1;
            low_cnt[ch] = '0;
            if (ch_phase[ch] == gpr_pkg::PH_LOW)
                low_len[ch] = old_lo;
            ch_phase[ch] = gpr_pkg::PH_HIGH;
            if (high_len[ch] == '0)
                y = int'(gpr_pkg::ONE_Q);
            else
                y = int'(ramp_level(high_cnt[ch], high_len[ch])) - int'(gpr_pkg::ONE_Q);
        end
        else
        begin
            low_cnt[ch] = (old_lo == gpr_pkg::CNT_MAX) ? old_lo : old_lo + 16'd1;
            high_cnt[ch] = '0;
            if (ch_phase[ch] == gpr_pkg::PH_HIGH)
                high_len[ch] = old_hi;
            ch_phase[ch] = gpr_pkg::PH_LOW;
            if (low_len[ch] == '0)
                y = -int'(gpr_pkg::ONE_Q);
            else
                y = int'(gpr_pkg::ONE_Q) - int'(ramp_level(low_cnt[ch], low_len[ch]));
        end
        return y[15:0];
    endfunction

    // Level on the wanted side of the threshold, mostly within the nominal +/-1.0 band.
    function automatic logic signed [15:0] pick_level(logic want_high);
        int                 lo;
        int                 hi;
        logic signed [15:0] v;
        if (want_high)
        begin
            lo = thresh_q;
            hi = 32767;
        end
        else
        begin
            lo = -32768;
            hi = int'(thresh_q) - 1;
        end
        if (hi < lo)
        begin
            lo = thresh_q;
            hi = 32767;
        end
        if ($urandom_range(0, 3) != 0 && lo <= 16384 && hi >= -16384)
        begin
            if (lo < -16384)
                lo = -16384;
            if (hi > 16384)
                hi = 16384;
        end
        v = 16'(lo + int'($urandom_range(0, hi - lo)));
        return v;
    endfunction

    // Alternating high and low runs of random length, with some raw noise mixed in.
    function automatic logic signed [15:0] next_activity(int ch);
        logic signed [15:0] v;
        if ($urandom_range(0, 9) == 0)
        begin
            v = 16'($urandom);
            return v;
        end
        if (run_left[ch] == 0)
        begin
            run_high[ch] = !run_high[ch];
            case ($urandom_range(0, 19))
                0:       run_left[ch] = $urandom_range(60, 250);
                1, 2:    run_left[ch] = 1;
                default: run_left[ch] = $urandom_range(2, 40);
            endcase
        end
        run_left[ch]--;
        return pick_level(run_high[ch]);
    endfunction

    task automatic send_item(gpr_pkg::item_t it, logic typed, gpr_pkg::result_t typed_res);
        gpr_pkg::result_t want;
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        item       <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (item_stall);
        want.shaped_a = shape_step(0, it.activity_a);
        want.shaped_b = shape_step(1, it.activity_b);
        if (typed)
            want = typed_res;
        shaped_q.push_back(want);
        items_sent++;
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        do @(posedge clk); while (shaped_q.size() != 0);
    endtask

    task automatic write_threshold(logic signed [15:0] v);
        cfg_data  <= v;
        cfg_write <= 1'b1;
        @(posedge clk);
        cfg_write <= 1'b0;
        thresh_q = v;
        cfg_writes++;
    endtask

    // Result side: checks each transfer and stalls in random bursts.
    initial
    begin
        int               stall_left;
        gpr_pkg::result_t want;
        stall_left = 0;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && !result_stall)
            begin
                if (shaped_q.size() == 0)
                begin
                    report_mismatch($sformatf("result with no item pending: %0d %0d",
                        result.shaped_a, result.shaped_b));
                end
                else
                begin
                    want = shaped_q.pop_front();
                    if (result.shaped_a !== want.shaped_a)
                        report_mismatch($sformatf("result %0d shaped_a: expected %0d, got %0d",
                            results_checked, want.shaped_a, result.shaped_a));
                    if (result.shaped_b !== want.shaped_b)
                        report_mismatch($sformatf("result %0d shaped_b: expected %0d, got %0d",
                            results_checked, want.shaped_b, result.shaped_b));
                    if (want.shaped_a == 16'sd16384 || want.shaped_a == -16'sd16384)
                        rail_outputs++;
                    results_checked++;
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                result_stall <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 15) == 0)
            begin
                stall_left = $urandom_range(0, 8);
                result_stall <= 1'b1;
            end
            else
            begin
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        gpr_pkg::item_t     it;
        gpr_pkg::result_t   res;
        logic signed [15:0] settings [NUM_SETTINGS];
        rst_n      <= 1'b0;
        cfg_write  <= 1'b0;
        cfg_data   <= '0;
        item_valid <= 1'b0;
        item       <= '0;
        thresh_q = gpr_pkg::THRESH_RESET;
        for (int ch = 0; ch < 2; ch++)
        begin
            ch_phase[ch] = gpr_pkg::PH_UNKNOWN;
            high_cnt[ch] = '0;
            low_cnt[ch]  = '0;
            high_len[ch] = '0;
            low_len[ch]  = '0;
            run_left[ch] = 0;
            run_high[ch] = 1'b0;
        end
        settings[0] = -16'sd16384;
        settings[1] = 16'sd16384;
        settings[2] = 16'sd0;
        settings[3] = 16'sh7FFF;
        settings[4] = 16'sh8000;
        settings[5] = 16'(int'($urandom_range(0, 32768)) - 16384);
        settings[6] = gpr_pkg::THRESH_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            it.activity_a = dir_rows[i].act_a;
            it.activity_b = dir_rows[i].act_b;
            res.shaped_a  = dir_rows[i].shaped_a;
            res.shaped_b  = dir_rows[i].shaped_b;
            send_item(it, dir_rows[i].typed, res);
        end
        wait_drained();

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_threshold(settings[s]);
            for (int n = 0; n < SETTING_ITEMS; n++)
            begin
                // The last setting runs with no idling on either side.
                if (n % 40 == 0)
                    idle_on = (s != NUM_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
                if (n == SETTING_ITEMS / 2)
                    wait_drained();
                it.activity_a = next_activity(0);
                it.activity_b = next_activity(1);
                send_item(it, 1'b0, '0);
            end
            wait_drained();
        end

        repeat (60) @(posedge clk);
        if (shaped_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", shaped_q.size()));
        $display("Run covered %0d items (%0d directed) across %0d threshold writes.",
            items_sent, DIR_ROWS, cfg_writes);
        $display("%0d results checked, %0d of them with channel A at a rail.",
            results_checked, rail_outputs);
        if (errors == 0)
            $display("gait_phase_ramp_shaper_core regression: pass");
        else
            $display("gait_phase_ramp_shaper_core regression: fail");
        $finish;
    end

    initial
    begin
        #(4 * 1000000);
        $display("Timed out with %0d results outstanding.", shaped_q.size());
        $display("gait_phase_ramp_shaper_core regression: fail");
        $finish;
    end

endmodule

`default_nettype wire
